// ===== sv/psq_pkg.sv =====
// Shared types, codes and the debouncer step function for the power source qualifier.
// Has no dependencies; power_source_qualifier imports it.
`default_nettype none

package psq_pkg;

	// Field and register widths.
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned MV_W    = 16;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned PER_W   = 16;
	localparam int unsigned PWR_W   = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VBUS_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEB_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PER  = 2'd2;

	// Register reset values.
	localparam logic [MV_W-1:0]  VBUS_MIN_RST  = 16'd36000;
	localparam logic [CNT_W-1:0] DEB_LEN_RST   = 4'd5;
	localparam logic [PER_W-1:0] BLINK_PER_RST = 16'd150;

	// Source classification codes.
	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_TYPE1 = 2'd1;
	localparam logic [1:0] SRC_TYPE2 = 2'd2;
	localparam logic [1:0] SRC_AUX   = 2'd3;

	// Cut cause codes.
	localparam logic [1:0] CUT_NONE    = 2'd0;
	localparam logic [1:0] CUT_VOLTAGE = 2'd1;
	localparam logic [1:0] CUT_NO_SRC  = 2'd2;

	// Available power in centiwatts.
	localparam logic [PWR_W-1:0] PWR_TYPE1_CW = 12'd1295;
	localparam logic [PWR_W-1:0] PWR_TYPE2_CW = 12'd2550;
	localparam logic [PWR_W-1:0] PWR_NONE_CW  = 12'd0;

	// State of one debouncer.
	typedef struct packed {
		logic             last;
		logic [CNT_W-1:0] count;
		logic             conf;
	} deb_t;

	// One debouncer update: equal samples count up to the length, a change restarts.
	function automatic deb_t deb_step(deb_t cur, logic smp, logic [CNT_W-1:0] len);
		deb_t nxt;
		nxt = cur;
		if (smp == cur.last) begin
			if (cur.count < len)
				nxt.count = cur.count + CNT_W'(1);
		end else begin
			nxt.count = '0;
			nxt.last  = smp;
		end
		if (nxt.count >= len)
			nxt.conf = smp;
		return nxt;
	endfunction

endpackage

`default_nettype wire

// ===== sv/power_source_qualifier.sv =====
// A request accepted into the input register moves on into the result register when
// that register is empty or its result is being taken; one request per cycle is
// sustained back to back while out_ready stays high. The debounce, ready and blink
// state is updated as a request moves from the input register to the result register.
// Reset (arst_n low, asynchronous) restores the default registers and clears all
// state, with the wait LED on; the first request after reset primes the debouncers.
`default_nettype none

module power_source_qualifier #(
	parameter int unsigned MAX_DEBOUNCE = 15
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration writes.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [psq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [psq_pkg::CFG_DATA_W-1:0] cfg_data,
	// Sample requests.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cdb_pin,
	input  wire logic                          t2p_pin,
	input  wire logic [psq_pkg::MV_W-1:0]       vbus_mv,
	input  wire logic                          driver_was_on,
	input  wire logic [psq_pkg::TICK_W-1:0]     now_ticks,
	// Results.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               poe_ok,
	output logic                               aux_ok,
	output logic                               vbus_ok,
	output logic [1:0]                         source,
	output logic                               ready_res,
	output logic                               resume_pulse,
	output logic                               cut_pulse,
	output logic [1:0]                         cut_cause,
	output logic                               wait_led,
	output logic [2:0]                         change_flags,
	output logic [psq_pkg::PWR_W-1:0]           power_cw
);
	import psq_pkg::*;

	// Effective length cap; the counter cannot exceed its own range.
	localparam int unsigned LEN_CAP = (MAX_DEBOUNCE > 15) ? 15 : MAX_DEBOUNCE;
	localparam logic [CNT_W-1:0] LEN_CAP_V = CNT_W'(LEN_CAP);

	// Configuration registers.
	logic [MV_W-1:0]  vbus_min_q;
	logic [CNT_W-1:0] deb_len_q;
	logic [PER_W-1:0] blink_per_q;

	// Block state.
	deb_t              deb_q [3];
	logic              primed_q;
	logic              ready_q;
	logic              blink_q;
	logic              led_q;
	logic [TICK_W-1:0] last_tick_q;

	// Input stage.
	logic              valid_s1;
	logic              cdb_s1;
	logic              t2p_s1;
	logic [MV_W-1:0]   mv_s1;
	logic              drv_s1;
	logic [TICK_W-1:0] now_s1;

	// Result stage.
	logic              valid_s2;
	logic              poe_s2, aux_s2, vb_s2, ready_s2, resume_s2, cut_s2, led_s2;
	logic [1:0]        src_s2, cause_s2;
	logic [2:0]        flags_s2;
	logic [PWR_W-1:0]  pwr_s2;

	// Next-state and result logic.
	logic              advance;
	logic [CNT_W-1:0]  len_eff;
	logic [2:0]        smp;
	deb_t              deb_cur [3];
	deb_t              deb_nxt [3];
	logic              poe_n, aux_n, vb_n, src_ok, ready_n;
	logic [1:0]        src_n, cause_n;
	logic              resume_n, cut_n;
	logic              blink_n, led_n;
	logic [TICK_W-1:0] last_tick_base, last_tick_n, elapsed;
	logic [PWR_W-1:0]  pwr_n;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// Configuration register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbus_min_q  <= VBUS_MIN_RST;
			deb_len_q   <= DEB_LEN_RST;
			blink_per_q <= BLINK_PER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VBUS_MIN:  vbus_min_q  <= cfg_data;
				REG_DEB_LEN:   deb_len_q   <= cfg_data[CNT_W-1:0];
				REG_BLINK_PER: blink_per_q <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: holds a request until the result stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cdb_s1 <= cdb_pin;
			t2p_s1 <= t2p_pin;
			mv_s1  <= vbus_mv;
			drv_s1 <= driver_was_on;
			now_s1 <= now_ticks;
		end
	end

	// Debouncing, classification, edge detection and blink timing.
	always_comb begin
		len_eff = (deb_len_q > LEN_CAP_V) ? LEN_CAP_V : deb_len_q;
		smp[0]  = cdb_s1;
		smp[1]  = !t2p_s1;
		smp[2]  = (mv_s1 >= vbus_min_q);

		for (int k = 0; k < 3; k++) begin
			deb_cur[k] = deb_q[k];
			if (!primed_q)
				deb_cur[k].last = smp[k];
			deb_nxt[k] = deb_step(deb_cur[k], smp[k], len_eff);
		end
		poe_n = deb_nxt[0].conf;
		aux_n = deb_nxt[1].conf;
		vb_n  = deb_nxt[2].conf;

		if (poe_n)
			src_n = aux_n ? SRC_TYPE2 : SRC_TYPE1;
		else if (aux_n)
			src_n = SRC_AUX;
		else
			src_n = SRC_NONE;
		src_ok  = (src_n != SRC_NONE);
		ready_n = src_ok && vb_n;

		resume_n = 1'b0;
		cut_n    = 1'b0;
		cause_n  = CUT_NONE;
		led_n    = led_q;
		if (ready_n && !ready_q) begin
			led_n    = 1'b0;
			resume_n = drv_s1;
		end else if (!ready_n && ready_q) begin
			cut_n   = 1'b1;
			cause_n = (src_ok && !vb_n) ? CUT_VOLTAGE : CUT_NO_SRC;
		end

		last_tick_base = primed_q ? last_tick_q : now_s1;
		elapsed        = now_s1 - last_tick_base;
		last_tick_n    = last_tick_base;
		blink_n        = blink_q;
		if (!ready_n && (elapsed >= TICK_W'(blink_per_q))) begin
			last_tick_n = now_s1;
			blink_n     = !blink_q;
			led_n       = !blink_q;
		end

		unique case (src_n)
			SRC_TYPE1: pwr_n = PWR_TYPE1_CW;
			SRC_TYPE2: pwr_n = PWR_TYPE2_CW;
			default:   pwr_n = PWR_NONE_CW;
		endcase
	end

	// State update, once per request moved into the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				deb_q[k] <= '0;
			primed_q    <= 1'b0;
			ready_q     <= 1'b0;
			blink_q     <= 1'b0;
			led_q       <= 1'b1;
			last_tick_q <= '0;
		end else if (advance) begin
			for (int k = 0; k < 3; k++)
				deb_q[k] <= deb_nxt[k];
			primed_q    <= 1'b1;
			ready_q     <= ready_n;
			blink_q     <= blink_n;
			led_q       <= led_n;
			last_tick_q <= last_tick_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			poe_s2    <= poe_n;
			aux_s2    <= aux_n;
			vb_s2     <= vb_n;
			src_s2    <= src_n;
			ready_s2  <= ready_n;
			resume_s2 <= resume_n;
			cut_s2    <= cut_n;
			cause_s2  <= cause_n;
			led_s2    <= led_n;
			flags_s2  <= {vb_n != deb_q[2].conf, aux_n != deb_q[1].conf,
			              poe_n != deb_q[0].conf};
			pwr_s2    <= pwr_n;
		end
	end

	assign out_valid    = valid_s2;
	assign poe_ok       = poe_s2;
	assign aux_ok       = aux_s2;
	assign vbus_ok      = vb_s2;
	assign source       = src_s2;
	assign ready_res    = ready_s2;
	assign resume_pulse = resume_s2;
	assign cut_pulse    = cut_s2;
	assign cut_cause    = cause_s2;
	assign wait_led     = led_s2;
	assign change_flags = flags_s2;
	assign power_cw     = pwr_s2;

`ifndef SYNTHESIS
	// A result never both resumes and cuts the driver.
	a_no_resume_and_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(resume_pulse && cut_pulse))
		else $error("resume and cut pulses in one result");

	// A cause is reported exactly with a cut.
	a_cause_with_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cut_pulse == (cut_cause != CUT_NONE)))
		else $error("cut cause does not match cut pulse");

	// Ready means a source is present and the bus voltage is confirmed.
	a_ready_def: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ready_res == ((source != SRC_NONE) && vbus_ok)))
		else $error("ready inconsistent with source and voltage");

	// The wait LED is off in every result taken while ready.
	a_led_off_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ready_res) |-> !wait_led)
		else $error("wait LED on while ready");

	// The held ready state follows the last result moved into the result stage.
	a_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (ready_q == ready_s2))
		else $error("ready state diverged from result");
`endif

endmodule

`default_nettype wire
